### rtl/core/dacs_pkg.sv
// dacs_pkg: shared types, constants and helpers of the decimal accumulator step unit
package dacs_pkg;

  localparam int unsigned WORD_W = 11;
  localparam int unsigned ADDR_W = 7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  // operation field of an input item
  localparam logic OPN_LOAD = 1'b0;
  localparam logic OPN_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_HALT  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_STORE = 4'd3,
    OP_LOAD  = 4'd5,
    OP_BRA   = 4'd6,
    OP_BRZ   = 4'd7,
    OP_BRP   = 4'd8,
    OP_IO    = 4'd9
  } opcode_e;

  // i/o sub-codes carried in the address digits
  localparam addr_t IO_INPUT = 7'd1;
  localparam addr_t IO_NUM   = 7'd2;
  localparam addr_t IO_CHAR  = 7'd22;

  localparam addr_t PC_LAST  = 7'd99;

  localparam word_t WORD_MAX = 11'sd999;
  localparam word_t WORD_MIN = -11'sd999;

  // word / 100 as (word * 41) >> 12, exact for 0..1023
  localparam logic [15:0] DIV100_MUL   = 16'd41;
  localparam int unsigned DIV100_SHIFT = 12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RANGE,
    S_DECODE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_fin;
    logic range_fin;
    logic decode;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic step_req;
    logic pc_ok;
    logic out_free;
  } dp_stat_t;

  function automatic word_t sat_word(input logic signed [WORD_W+1:0] v);
    word_t r;
    if (v > 13'sd999) begin
      r = WORD_MAX;
    end else if (v < -13'sd999) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // hundreds digit back to its weight
  function automatic logic [9:0] times_hundred(input logic [3:0] op);
    logic [9:0] r;
    case (op)
      4'd0:    r = 10'd0;
      4'd1:    r = 10'd100;
      4'd2:    r = 10'd200;
      4'd3:    r = 10'd300;
      4'd4:    r = 10'd400;
      4'd5:    r = 10'd500;
      4'd6:    r = 10'd600;
      4'd7:    r = 10'd700;
      4'd8:    r = 10'd800;
      4'd9:    r = 10'd900;
      4'd10:   r = 10'd1000;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/dacs_if.sv
// dacs_if: input and result channel interfaces of the step unit

interface dacs_in_if;
  import dacs_pkg::*;
  logic  valid;
  logic  ready;
  logic  operation;
  addr_t load_address;
  word_t load_word;
  word_t typed_value;

  modport source (output valid, operation, load_address, load_word, typed_value,
                  input ready);
  modport sink   (input valid, operation, load_address, load_word, typed_value,
                  output ready);
endinterface

interface dacs_out_if;
  import dacs_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  addr_t      program_counter;
  word_t      acc_value;
  logic       out_valid;
  logic       out_is_char;
  word_t      out_value;

  modport source (output valid, status, program_counter, acc_value, out_valid,
                  out_is_char, out_value, input ready);
  modport sink   (input valid, status, program_counter, acc_value, out_valid,
                  out_is_char, out_value, output ready);
endinterface

### rtl/core/dacs_ctrl.sv
// dacs_ctrl: sequencing state machine of the step unit
module dacs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dacs_pkg::dp_stat_t stat_i,
  output dacs_pkg::dp_cmd_t  cmd_o
);
  import dacs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!stat_i.step_req) begin
            state_d = S_LOAD;
          end else if (!stat_i.pc_ok) begin
            state_d = S_RANGE;
          end else begin
            state_d = S_DECODE;
          end
        end
      end
      S_LOAD, S_RANGE, S_EXEC: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DECODE: state_d = S_EXEC;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_LOAD:   cmd_o.load_fin  = stat_i.out_free;
      S_RANGE:  cmd_o.range_fin = stat_i.out_free;
      S_DECODE: cmd_o.decode    = 1'b1;
      S_EXEC:   cmd_o.exec      = stat_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/dacs_dp.sv
// dacs_dp: word store, registers, decode, execute and result register
module dacs_dp #(
  parameter int unsigned MEMORY_WORDS = 100
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dacs_pkg::dp_cmd_t  cmd_i,
  output dacs_pkg::dp_stat_t stat_o,
  input  logic               operation_i,
  input  dacs_pkg::addr_t    load_address_i,
  input  dacs_pkg::word_t    load_word_i,
  input  dacs_pkg::word_t    typed_value_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output logic [1:0]         status_o,
  output dacs_pkg::addr_t    program_counter_o,
  output dacs_pkg::word_t    acc_value_o,
  output logic               out_valid_o,
  output logic               out_is_char_o,
  output dacs_pkg::word_t    out_value_o
);
  import dacs_pkg::*;

  localparam int unsigned AW    = $clog2(MEMORY_WORDS);
  localparam addr_t       DEPTH = ADDR_W'(MEMORY_WORDS);

  word_t                  mem_q [MEMORY_WORDS];
  logic [MEMORY_WORDS-1:0] vld_q;
  word_t                  rdata_q;

  addr_t pc_q;
  word_t acc_q;
  addr_t ld_addr_q;
  word_t ld_word_q;
  word_t typed_q;
  logic [3:0] op_q;
  addr_t      ad_q;
  logic       neg_q;

  logic       res_vld_q;
  logic [1:0] res_status_q;
  addr_t      res_pc_q;
  word_t      res_acc_q;
  logic       res_ov_q;
  logic       res_oc_q;
  word_t      res_oval_q;

  // decode of the fetched word
  logic [9:0]  word_mag;
  logic [15:0] div_prod;
  logic [3:0]  op_dec;
  logic [9:0]  ad_wide;
  addr_t       ad_dec;

  assign word_mag = rdata_q[9:0];
  assign div_prod = {6'd0, word_mag} * DIV100_MUL;
  assign op_dec   = div_prod[DIV100_SHIFT+3:DIV100_SHIFT];
  assign ad_wide  = word_mag - times_hundred(op_dec);
  assign ad_dec   = ad_wide[ADDR_W-1:0];

  assign stat_o.step_req = (operation_i == OPN_STEP);
  assign stat_o.pc_ok    = (pc_q < DEPTH);
  assign stat_o.out_free = !res_vld_q || res_ready_i;

  // memory ports
  logic  rd_en;
  addr_t rd_addr;
  logic  wr_en;
  addr_t wr_addr;
  word_t wr_data;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pc_q;
    if (cmd_i.accept && stat_o.step_req && stat_o.pc_ok) begin
      rd_en   = 1'b1;
      rd_addr = pc_q;
    end else if (cmd_i.decode && !rdata_q[WORD_W-1] && (ad_dec < DEPTH)) begin
      rd_en   = 1'b1;
      rd_addr = ad_dec;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ad_q;
    wr_data = acc_q;
    if (cmd_i.load_fin && (ld_addr_q < DEPTH)) begin
      wr_en   = 1'b1;
      wr_addr = ld_addr_q;
      wr_data = sat_word({{2{ld_word_q[WORD_W-1]}}, ld_word_q});
    end else if (cmd_i.exec && !neg_q && (op_q == OP_STORE) && (ad_q < DEPTH)) begin
      wr_en   = 1'b1;
      wr_addr = ad_q;
      wr_data = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  // unwritten words read as zero
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= vld_q[rd_addr[AW-1:0]] ? mem_q[rd_addr[AW-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  // execute
  logic signed [WORD_W+1:0] acc_ext;
  logic signed [WORD_W+1:0] opd_ext;
  logic [1:0] ex_status;
  word_t      ex_acc;
  addr_t      ex_pc;
  logic       ex_ov;
  logic       ex_oc;

  assign acc_ext = {{2{acc_q[WORD_W-1]}}, acc_q};
  assign opd_ext = {{2{rdata_q[WORD_W-1]}}, rdata_q};

  always_comb begin
    ex_status = ST_OK;
    ex_acc    = acc_q;
    ex_pc     = pc_q;
    ex_ov     = 1'b0;
    ex_oc     = 1'b0;
    if (neg_q) begin
      ex_status = ST_ILLEGAL;
    end else begin
      case (op_q)
        OP_HALT:  ex_status = ST_HALT;
        OP_ADD:   ex_acc    = sat_word(acc_ext + opd_ext);
        OP_SUB:   ex_acc    = sat_word(acc_ext - opd_ext);
        OP_STORE: ex_acc    = acc_q;
        OP_LOAD:  ex_acc    = rdata_q;
        OP_BRA:   ex_pc     = ad_q;
        OP_BRZ: begin
          if (acc_q == '0) begin
            ex_pc = ad_q;
          end
        end
        OP_BRP: begin
          if (!acc_q[WORD_W-1]) begin
            ex_pc = ad_q;
          end
        end
        OP_IO: begin
          if (ad_q == IO_INPUT) begin
            ex_acc = sat_word({{2{typed_q[WORD_W-1]}}, typed_q});
          end else if (ad_q == IO_NUM) begin
            ex_ov = 1'b1;
          end else if (ad_q == IO_CHAR) begin
            ex_ov = 1'b1;
            ex_oc = 1'b1;
          end else begin
            ex_status = ST_ILLEGAL;
          end
        end
        default: ex_status = ST_ILLEGAL;
      endcase
    end
  end

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      acc_q <= '0;
    end else if (cmd_i.decode) begin
      pc_q <= pc_q + 7'd1;
    end else if (cmd_i.exec) begin
      pc_q  <= ex_pc;
      acc_q <= ex_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ld_addr_q <= load_address_i;
      ld_word_q <= load_word_i;
      typed_q   <= typed_value_i;
    end
    if (cmd_i.decode) begin
      op_q  <= op_dec;
      ad_q  <= ad_dec;
      neg_q <= rdata_q[WORD_W-1];
    end
  end

  // result register
  logic res_load;
  assign res_load = cmd_i.exec || cmd_i.load_fin || cmd_i.range_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_load) begin
      res_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      if (cmd_i.exec) begin
        res_status_q <= ex_status;
        res_pc_q     <= ex_pc;
        res_acc_q    <= ex_acc;
        res_ov_q     <= ex_ov;
        res_oc_q     <= ex_oc;
        res_oval_q   <= ex_ov ? acc_q : '0;
      end else begin
        res_status_q <= cmd_i.range_fin ? ST_RANGE : ST_OK;
        res_pc_q     <= pc_q;
        res_acc_q    <= acc_q;
        res_ov_q     <= 1'b0;
        res_oc_q     <= 1'b0;
        res_oval_q   <= '0;
      end
    end
  end

  assign res_valid_o       = res_vld_q;
  assign status_o          = res_status_q;
  assign program_counter_o = res_pc_q;
  assign acc_value_o       = res_acc_q;
  assign out_valid_o       = res_ov_q;
  assign out_is_char_o     = res_oc_q;
  assign out_value_o       = res_oval_q;

endmodule

### rtl/core/decimal_accumulator_cpu_step_unit.sv
// decimal_accumulator_cpu_step_unit: top level of the decimal accumulator step unit
//
//   channel  | dir | modport | payload
//   ---------+-----+---------+--------------------------------------------------
//   in_i     | in  | sink    | operation, load_address, load_word, typed_value
//   out_o    | out | source  | status, program_counter, acc_value, out_valid,
//            |     |         | out_is_char, out_value
//
// a step item passes accept, which fetches the word at the counter, then decode, which
// decodes it and reads the operand, then execute, which executes and writes back; the single
// read port and single write port of the word store set this order
// a load item or an out-of-range counter passes accept, then finish
// reset clears counter, accumulator and per-word written flags; unwritten words read zero
// while a result waits one more item is accepted and then holds in its last state
module decimal_accumulator_cpu_step_unit #(
  parameter int unsigned MEMORY_WORDS = 100
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dacs_in_if.sink           in_i,
  dacs_out_if.source        out_o
);
  import dacs_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: accepts a transfer only while idle
  dacs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: word store, counter, accumulator and result register
  dacs_dp #(
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (in_i.operation),
    .load_address_i    (in_i.load_address),
    .load_word_i       (in_i.load_word),
    .typed_value_i     (in_i.typed_value),
    .res_ready_i       (out_o.ready),
    .res_valid_o       (out_o.valid),
    .status_o          (out_o.status),
    .program_counter_o (out_o.program_counter),
    .acc_value_o       (out_o.acc_value),
    .out_valid_o       (out_o.out_valid),
    .out_is_char_o     (out_o.out_is_char),
    .out_value_o       (out_o.out_value)
  );

endmodule

### rtl/core/dacs_checker.sv
// dacs_checker: port-level assertions of the step unit and their bind
module dacs_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input logic [1:0]      status_i,
  input dacs_pkg::addr_t program_counter_i,
  input dacs_pkg::word_t acc_value_i,
  input logic            out_valid_i,
  input logic            out_is_char_i,
  input dacs_pkg::word_t out_value_i
);
  import dacs_pkg::*;

  // the unit is busy right after taking a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i)
      && $stable(program_counter_i) && $stable(acc_value_i))
    else $error("stalled result changed");

  a_range_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == ST_RANGE) |-> (program_counter_i > PC_LAST))
    else $error("out-of-range status with counter in range");

  // an output instruction sends the unchanged accumulator
  a_output_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && out_valid_i |-> (status_i == ST_OK) && (out_value_i == acc_value_i))
    else $error("output value differs from accumulator");

  a_no_output_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !out_valid_i |-> !out_is_char_i && (out_value_i == '0))
    else $error("output fields set without output");

endmodule

bind decimal_accumulator_cpu_step_unit dacs_checker u_dacs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .res_valid_i       (out_o.valid),
  .res_ready_i       (out_o.ready),
  .status_i          (out_o.status),
  .program_counter_i (out_o.program_counter),
  .acc_value_i       (out_o.acc_value),
  .out_valid_i       (out_o.out_valid),
  .out_is_char_i     (out_o.out_is_char),
  .out_value_i       (out_o.out_value)
);
